// File: design/kmhs_pkg.sv
// Shared types and constants for the keyboard matrix hold/scan block.
package kmhs_pkg;

   localparam int unsigned ROWS = 8;
   localparam int unsigned HOLD_WIDTH = 16;

   localparam logic [HOLD_WIDTH-1:0] HOLD_RESET = 16'd10000;
   localparam logic [7:0] PORT_IDLE     = 8'hff;
   localparam logic [7:0] MOD_FORCE     = 8'hf0;
   localparam logic [7:0] LOW_NIBBLE    = 8'h0f;
   localparam int unsigned MOD_CODE_BIT = 6;

   typedef struct packed {
      logic       key_valid;
      logic [6:0] key_code;
      logic [7:0] port_a_value;
      logic [7:0] port_c_value;
      logic       scan_request;
   } req_type;

   typedef struct packed {
      logic [7:0] port_b_read;
      logic [7:0] port_c_read;
      logic       key_accepted;
   } rsp_type;

endpackage

// File: design/keyboard_matrix_hold_scan.sv
// Top level: tick channel, result channel, hold time register.
//
// Each request transaction is one emulation tick: an optional key code,
// the CPU's port A and port C values and a scan flag. Each tick gives
// exactly one response transaction with the port B and port C read values
// and a flag that says whether the pending key was consumed.
// A request is captured in an input register, and the tick is processed
// once the response register is free, writing the matrix state and the
// response register together; rsp_valid is registered and is set then.
// Throughput is one tick per cycle while rsp_ready keeps up; the input
// register and the response register are separate stages, so a new
// request is taken while a response waits, and only a stalled response
// with a full input stage holds off req_ready. When rsp_ready stays low,
// the response and the captured request hold their values.
// csr_write_enable loads the hold time (ticks a key stays down) on the
// clock edge; write it only while no tick is in flight.
// Synchronous reset empties both stages, clears the matrix, sets the
// modifiers and both read values to 0xff and the hold time to 10000.
module keyboard_matrix_hold_scan
   import kmhs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_write_enable,
   input  logic [HOLD_WIDTH-1:0] csr_write_data
);

   logic                  in_valid_ff;
   req_type               in_data_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   logic [HOLD_WIDTH-1:0] hold_ticks_ff;
   logic                  advance;
   rsp_type               tick_rsp;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= tick_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= HOLD_RESET;
      end else if (csr_write_enable) begin
         hold_ticks_ff <= csr_write_data;
      end
   end

   kmhs_matrix u_matrix (
      .clock      (clock),
      .reset      (reset),
      .tick_en    (advance),
      .req        (in_data_ff),
      .hold_ticks (hold_ticks_ff),
      .rsp        (tick_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/kmhs_matrix.sv
// Matrix state, hold counter and per-tick update with port B/C read values.
module kmhs_matrix
   import kmhs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tick_en,
   input  req_type               req,
   input  logic [HOLD_WIDTH-1:0] hold_ticks,
   output rsp_type               rsp
);

   logic [7:0]            row_bits_ff [ROWS];
   logic [7:0]            row_bits_in [ROWS];
   logic [7:0]            modifier_ff;
   logic [7:0]            modifier_in;
   logic [HOLD_WIDTH-1:0] hold_count_ff;
   logic [HOLD_WIDTH-1:0] hold_count_in;
   logic [7:0]            port_b_ff;
   logic [7:0]            port_b_in;
   logic [7:0]            port_c_ff;
   logic [7:0]            port_c_in;
   logic                  accepted;
   logic [2:0]            row_sel;
   logic [2:0]            col_sel;
   logic [7:0]            scan_acc;
   logic [7:0]            row_or_all;

   assign row_sel = req.key_code[5:3];
   assign col_sel = req.key_code[2:0];

   always_comb begin
      row_bits_in   = row_bits_ff;
      modifier_in   = modifier_ff;
      hold_count_in = hold_count_ff;
      port_b_in     = port_b_ff;
      port_c_in     = port_c_ff;
      accepted      = 1'b0;
      scan_acc      = '0;

      if (hold_count_ff != '0) begin
         hold_count_in = hold_count_ff - 1'b1;
         if (hold_count_in == '0) begin
            // key released: clear matrix, modifiers follow port C
            for (int i = 0; i < ROWS; i++) begin
               row_bits_in[i] = '0;
            end
            modifier_in = req.port_c_value | MOD_FORCE;
            port_b_in   = PORT_IDLE;
         end
         port_c_in = (req.port_c_value & LOW_NIBBLE) | modifier_in;
      end else if (req.key_valid) begin
         accepted = 1'b1;
         if (req.key_code[MOD_CODE_BIT]) begin
            modifier_in = {~req.key_code[3:0], 4'h0};
         end else begin
            row_bits_in[row_sel] = 8'b1 << col_sel;
         end
         hold_count_in = hold_ticks;
      end

      if (req.scan_request) begin
         for (int i = 0; i < ROWS; i++) begin
            if (!req.port_a_value[i]) begin
               scan_acc = scan_acc | row_bits_in[i];
            end
         end
         port_b_in = ~scan_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROWS; i++) begin
            row_bits_ff[i] <= '0;
         end
         modifier_ff   <= PORT_IDLE;
         hold_count_ff <= '0;
         port_b_ff     <= PORT_IDLE;
         port_c_ff     <= PORT_IDLE;
      end else if (tick_en) begin
         row_bits_ff   <= row_bits_in;
         modifier_ff   <= modifier_in;
         hold_count_ff <= hold_count_in;
         port_b_ff     <= port_b_in;
         port_c_ff     <= port_c_in;
      end
   end

   assign rsp.port_b_read  = port_b_in;
   assign rsp.port_c_read  = port_c_in;
   assign rsp.key_accepted = accepted;

   always_comb begin
      row_or_all = '0;
      for (int i = 0; i < ROWS; i++) begin
         row_or_all = row_or_all | row_bits_ff[i];
      end
   end

   // a key is never taken while the previous one is still held
   a_no_accept_while_held: assert property (@(posedge clock) disable iff (reset)
      (tick_en && hold_count_ff != '0) |-> !rsp.key_accepted)
      else $error("key accepted while hold counter running");

   // a taken matrix key leaves exactly one column bit in its row
   a_row_onehot: assert property (@(posedge clock) disable iff (reset)
      (tick_en && rsp.key_accepted && !req.key_code[MOD_CODE_BIT])
      |=> $onehot(row_bits_ff[$past(row_sel)]))
      else $error("accepted key did not write a single column bit");

   // counter expiry releases every row
   a_expiry_clears: assert property (@(posedge clock) disable iff (reset)
      (tick_en && hold_count_ff == HOLD_WIDTH'(1)) |=> (row_or_all == '0))
      else $error("matrix not cleared on hold expiry");

   // state only moves on a processed tick
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !tick_en |=> $stable(hold_count_ff))
      else $error("hold counter changed without a tick");

endmodule

// File: bench/keyboard_matrix_hold_scan_checker.sv
// Checker for the keyboard matrix block: predicts every tick and compares the responses.
`timescale 1ns / 1ps

module keyboard_matrix_hold_scan_checker
   import kmhs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_write_enable,
   input  logic [HOLD_WIDTH-1:0] csr_write_data,
   output int                    mismatch_count,
   output int                    pending_ticks,
   output int                    ticks_checked,
   output int                    keys_taken,
   output int                    releases_seen
);

   logic [7:0]            matrix_rows [ROWS];
   logic [7:0]            modifier_lines;
   logic [HOLD_WIDTH-1:0] hold_left;
   logic [HOLD_WIDTH-1:0] hold_setting;
   logic [7:0]            port_b_latch;
   logic [7:0]            port_c_latch;
   rsp_type               expected_reads [$];

   // One emulation tick: hold countdown or key intake first, then the scan.
   function automatic rsp_type predict_tick(req_type tick);
      rsp_type    reads;
      logic [7:0] column_or;
      reads.key_accepted = 1'b0;
      if (hold_left != '0) begin
         hold_left--;
         if (hold_left == '0) begin
            foreach (matrix_rows[r]) matrix_rows[r] = '0;
            modifier_lines = tick.port_c_value | MOD_FORCE;
            port_b_latch   = PORT_IDLE;
            releases_seen++;
         end
         port_c_latch = (tick.port_c_value & LOW_NIBBLE) | modifier_lines;
      end else if (tick.key_valid) begin
         // modifier code: inverted low code bits land in the upper nibble
         if (tick.key_code[MOD_CODE_BIT]) begin
            modifier_lines = {~tick.key_code[3:0], 4'h0};
         end else begin
            matrix_rows[tick.key_code[5:3]] = 8'h01 << tick.key_code[2:0];
         end
         hold_left          = hold_setting;
         reads.key_accepted = 1'b1;
         keys_taken++;
      end
      if (tick.scan_request) begin
         column_or = '0;
         for (int r = 0; r < ROWS; r++) begin
            if (!tick.port_a_value[r]) column_or |= matrix_rows[r];
         end
         port_b_latch = ~column_or;
      end
      reads.port_b_read = port_b_latch;
      reads.port_c_read = port_c_latch;
      return reads;
   endfunction

   always @(posedge clock) begin : channel_watch
      rsp_type want;
      if (reset) begin
         foreach (matrix_rows[r]) matrix_rows[r] = '0;
         modifier_lines = '1;
         hold_left      = '0;
         hold_setting   = HOLD_RESET;
         port_b_latch   = PORT_IDLE;
         port_c_latch   = PORT_IDLE;
         expected_reads.delete();
      end else begin
         if (csr_write_enable) hold_setting = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_reads.size() == 0) begin
               $error("response transaction with no tick outstanding: %h", rsp_data);
               mismatch_count++;
            end else begin
               want = expected_reads.pop_front();
               ticks_checked++;
               if (rsp_data.port_b_read !== want.port_b_read) begin
                  $error("port_b_read: expected %h, actual %h",
                         want.port_b_read, rsp_data.port_b_read);
                  mismatch_count++;
               end
               if (rsp_data.port_c_read !== want.port_c_read) begin
                  $error("port_c_read: expected %h, actual %h",
                         want.port_c_read, rsp_data.port_c_read);
                  mismatch_count++;
               end
               if (rsp_data.key_accepted !== want.key_accepted) begin
                  $error("key_accepted: expected %b, actual %b",
                         want.key_accepted, rsp_data.key_accepted);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) expected_reads.push_back(predict_tick(req_data));
      end
      pending_ticks <= expected_reads.size();
   end

endmodule

// File: bench/keyboard_matrix_hold_scan_test.sv
// Testbench top for the keyboard matrix block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module keyboard_matrix_hold_scan_test;
   import kmhs_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int CHOKE_CYCLES   = 80;
   localparam int SETTLE_CYCLES  = 6;

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   req_type               req_data         = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_enable = 1'b0;
   logic [HOLD_WIDTH-1:0] csr_write_data   = '0;

   int mismatch_count;
   int pending_ticks;
   int ticks_checked;
   int keys_taken;
   int releases_seen;
   int idle_cycles    = 0;
   int choke_requests = 0;
   bit paced          = 1'b1;

   keyboard_matrix_hold_scan i_dut (.*);

   keyboard_matrix_hold_scan_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response side: random stall per transaction, plus one long hold-off on request.
   initial begin : response_sink
      int stall;
      int chokes_served;
      chokes_served = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (chokes_served != choke_requests) begin
            chokes_served = choke_requests;
            stall         = CHOKE_CYCLES;
         end else begin
            stall = paced ? $urandom_range(0, 14) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic offer_tick(input req_type tick);
      int gap;
      gap = paced ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= tick;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic offer_fields(input logic kv, input logic [6:0] code,
                               input logic [7:0] pa, input logic [7:0] pc,
                               input logic scan);
      req_type tick;
      tick = '{key_valid: kv, key_code: code, port_a_value: pa,
               port_c_value: pc, scan_request: scan};
      offer_tick(tick);
   endtask

   function automatic req_type random_tick();
      req_type tick;
      tick.key_valid = ($urandom_range(0, 9) < 7);
      tick.key_code  = 7'($urandom_range(0, 127));
      case ($urandom_range(0, 3))
         0: tick.port_a_value = ~(8'h01 << $urandom_range(0, 7));
         1: tick.port_a_value = 8'($urandom);
         2: tick.port_a_value = 8'($urandom & $urandom);
         default: tick.port_a_value = $urandom_range(0, 1) ? 8'h00 : 8'hff;
      endcase
      tick.port_c_value = 8'($urandom);
      tick.scan_request = ($urandom_range(0, 9) < 6);
      return tick;
   endfunction

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_ticks != 0);
   endtask

   task automatic load_hold_time(input logic [HOLD_WIDTH-1:0] ticks);
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= ticks;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input logic [HOLD_WIDTH-1:0] hold, input int items,
                            input int choke_at, input int drain_at);
      load_hold_time(hold);
      for (int n = 0; n < items; n++) begin
         if (n == drain_at) drain_responses();
         if (n == choke_at) begin
            // receiver holds off while ticks keep coming, so both stages fill
            paced          <= 1'b0;
            choke_requests <= choke_requests + 1;
         end else if (n == choke_at + 30 || n % 40 == 0) begin
            paced <= ($urandom_range(0, 3) != 0);
         end
         offer_tick(random_tick());
      end
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset hold time: keyless ticks only, a key here would stay down 10000 ticks
      offer_fields(1'b0, 7'h7f, 8'hff, 8'hff, 1'b1);
      offer_fields(1'b0, 7'h00, 8'h00, 8'h00, 1'b1);
      offer_fields(1'b0, 7'h55, 8'haa, 8'h55, 1'b0);

      load_hold_time(16'd2);
      offer_fields(1'b1, 7'h00, 8'hfe, 8'h00, 1'b1);
      offer_fields(1'b1, 7'h3f, 8'hfe, 8'h3c, 1'b1);
      offer_fields(1'b0, 7'h00, 8'h00, 8'ha5, 1'b1);
      offer_fields(1'b1, 7'h7f, 8'hff, 8'h00, 1'b0);
      offer_fields(1'b0, 7'h00, 8'hff, 8'h0a, 1'b0);
      offer_fields(1'b0, 7'h00, 8'hff, 8'hff, 1'b0);
      offer_fields(1'b1, 7'h40, 8'hff, 8'h00, 1'b1);
      offer_fields(1'b1, 7'h3f, 8'h00, 8'h03, 1'b1);
      offer_fields(1'b0, 7'h00, 8'hff, 8'h00, 1'b0);
      offer_fields(1'b1, 7'h3f, 8'h7f, 8'hff, 1'b1);
      offer_fields(1'b1, 7'h05, 8'h00, 8'hff, 1'b1);
      offer_fields(1'b0, 7'h00, 8'h00, 8'hff, 1'b1);

      // one-tick hold: release and scan fall in the same tick
      load_hold_time(16'd1);
      offer_fields(1'b1, 7'h2a, 8'hdf, 8'h00, 1'b1);
      offer_fields(1'b1, 7'h12, 8'hdf, 8'h5a, 1'b1);

      // zero hold: keys are never released; a key replaces its row, so rows pile up
      load_hold_time(16'd0);
      offer_fields(1'b1, 7'h00, 8'hff, 8'h00, 1'b0);
      offer_fields(1'b1, 7'h07, 8'hff, 8'h00, 1'b0);
      offer_fields(1'b1, 7'h3f, 8'hff, 8'h00, 1'b0);
      offer_fields(1'b1, 7'h08, 8'h00, 8'hff, 1'b1);
      offer_fields(1'b1, 7'h45, 8'hff, 8'hff, 1'b1);
      offer_fields(1'b0, 7'h00, 8'hfe, 8'hff, 1'b1);

      run_phase(16'd1, 110, -1, -1);
      run_phase(16'd0, 90, -1, -1);
      run_phase(16'd2, 140, -1, 60);
      run_phase(16'd5, 140, 81, -1);
      run_phase(16'd17, 110, -1, -1);
      run_phase(16'($urandom_range(1, 40)), 140, -1, -1);
      run_phase(16'd90, 160, -1, -1);
      run_phase(16'hffff, 60, -1, -1);

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d ticks checked, %0d keys taken into the matrix, %0d hold expiries",
               ticks_checked, keys_taken, releases_seen);
      $display("hold times 0 to 65535 after the reset value, stalls and gaps on both sides");
      if (mismatch_count == 0 && pending_ticks == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
